// ===== sv/charset_detect_stream_core_defines.svh =====
`ifndef CHARSET_DETECT_STREAM_CORE_DEFINES_SVH
`define CHARSET_DETECT_STREAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/csd_pkg.sv =====
package csd_pkg;

    localparam int unsigned CSD_QUEUE_DEPTH = 2;

    localparam logic [7:0] BYTE_00 = 8'h00;
    localparam logic [7:0] BYTE_FE = 8'hFE;
    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_81 = 8'h81;
    localparam logic [7:0] BYTE_40 = 8'h40;
    localparam logic [7:0] BYTE_80 = 8'h80;
    localparam logic [7:0] MASK_FC = 8'hFC;
    localparam logic [7:0] SURR_HI = 8'hD8;
    localparam logic [7:0] SURR_LO = 8'hDC;
    localparam logic [7:0] MASK_C0 = 8'hC0;
    localparam logic [7:0] MASK_E0 = 8'hE0;
    localparam logic [7:0] MASK_F0 = 8'hF0;
    localparam logic [7:0] MASK_F8 = 8'hF8;
    localparam logic [7:0] BOM8_0  = 8'hEF;
    localparam logic [7:0] BOM8_1  = 8'hBB;
    localparam logic [7:0] BOM8_2  = 8'hBF;

    localparam logic [1:0] BOM_SIZE_NONE  = 2'd0;
    localparam logic [1:0] BOM_SIZE_UTF16 = 2'd2;
    localparam logic [1:0] BOM_SIZE_UTF8  = 2'd3;

    localparam logic [2:0] BYTE_COUNT_MAX = 3'd5;

    typedef enum logic [2:0] {
        CS_UNKNOWN = 3'd0,
        CS_ANSI    = 3'd1,
        CS_UTF8    = 3'd2,
        CS_LE      = 3'd3,
        CS_BE      = 3'd4
    } t_charset;

    // Final stream summary handed from front to back
    typedef struct packed {
        logic [31:0] head_bytes;
        logic [2:0]  byte_count;
        logic        ascii_ok;
        logic        gbk_ok;
        logic        utf8_ok;
        logic        le_ok;
        logic        be_ok;
    } t_snap;

    typedef struct packed {
        logic low_due;
        logic fail;
    } t_surr;

    function automatic t_surr surrogate_step(input logic [7:0] b, input t_surr cur);
        t_surr      nxt;
        logic [7:0] top;
        nxt = cur;
        top = b & MASK_FC;
        priority if (cur.low_due) begin
            if (top == SURR_LO) nxt.low_due = 1'b0;
            else nxt.fail = 1'b1;
        end else if (top == SURR_HI) begin
            nxt.low_due = 1'b1;
        end else if (top == SURR_LO) begin
            nxt.fail = 1'b1;
        end
        return nxt;
    endfunction

    function automatic t_charset bom_charset(input logic [31:0] head, input logic [2:0] cnt);
        logic [7:0] h0, h1, h2, h3;
        t_charset   cs;
        h0 = head[7:0];
        h1 = head[15:8];
        h2 = head[23:16];
        h3 = head[31:24];
        priority if (cnt >= 3'd4 && h0 == BYTE_00 && h1 == BYTE_00
                     && h2 == BYTE_FE && h3 == BYTE_FF) begin
            cs = CS_UNKNOWN;
        end else if (cnt >= 3'd4 && h0 == BYTE_FF && h1 == BYTE_FE
                     && h2 == BYTE_00 && h3 == BYTE_00) begin
            cs = (cnt == 3'd4) ? CS_LE : CS_UNKNOWN;
        end else if (cnt >= 3'd3 && h0 == BOM8_0 && h1 == BOM8_1 && h2 == BOM8_2) begin
            cs = CS_UTF8;
        end else if (cnt >= 3'd2 && h0 == BYTE_FF && h1 == BYTE_FE) begin
            cs = CS_LE;
        end else if (cnt >= 3'd2 && h0 == BYTE_FE && h1 == BYTE_FF) begin
            cs = CS_BE;
        end else begin
            cs = CS_UNKNOWN;
        end
        return cs;
    endfunction

    function automatic logic [1:0] bom_size(input t_charset cs);
        logic [1:0] sz;
        unique case (cs)
            CS_UTF8:        sz = BOM_SIZE_UTF8;
            CS_LE, CS_BE:   sz = BOM_SIZE_UTF16;
            default:        sz = BOM_SIZE_NONE;
        endcase
        return sz;
    endfunction

    function automatic t_charset content_charset(input t_snap s);
        t_charset cs;
        priority if (s.ascii_ok) cs = CS_ANSI;
        else if (s.gbk_ok)      cs = s.utf8_ok ? CS_UTF8 : CS_ANSI;
        else if (s.utf8_ok)     cs = CS_UTF8;
        else if (s.le_ok)       cs = CS_LE;
        else if (s.be_ok)       cs = CS_BE;
        else                    cs = CS_UNKNOWN;
        return cs;
    endfunction

endpackage

// ===== sv/csd_front.sv =====
`include "charset_detect_stream_core_defines.svh"

module csd_front
    import csd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_push,
    output t_snap      o_snap
);

    logic [31:0] r_head_bytes, n_head_bytes;
    logic [2:0]  r_byte_count, n_byte_count;
    logic        r_length_odd, n_length_odd;
    logic        r_ascii_fail, n_ascii_fail;
    logic        r_gbk_trail_due, n_gbk_trail_due;
    logic        r_gbk_fail, n_gbk_fail;
    logic [1:0]  r_utf8_cont_left, n_utf8_cont_left;
    logic        r_utf8_fail, n_utf8_fail;
    t_surr       r_le, n_le;
    t_surr       r_be, n_be;

    always_comb begin
        n_head_bytes     = r_head_bytes;
        n_byte_count     = r_byte_count;
        n_ascii_fail     = r_ascii_fail;
        n_gbk_trail_due  = r_gbk_trail_due;
        n_gbk_fail       = r_gbk_fail;
        n_utf8_cont_left = r_utf8_cont_left;
        n_utf8_fail      = r_utf8_fail;
        n_le             = r_le;
        n_be             = r_be;
        n_length_odd     = !r_length_odd;

        if (r_byte_count < 3'd4) begin
            n_head_bytes[{r_byte_count[1:0], 3'b000} +: 8] = i_data_byte;
        end
        if (r_byte_count < BYTE_COUNT_MAX) begin
            n_byte_count = r_byte_count + 3'd1;
        end

        if (i_data_byte >= BYTE_80) n_ascii_fail = 1'b1;

        priority if (r_gbk_trail_due) begin
            if (i_data_byte < BYTE_40 || i_data_byte == BYTE_FF) n_gbk_fail = 1'b1;
            n_gbk_trail_due = 1'b0;
        end else if (i_data_byte >= BYTE_80) begin
            if (i_data_byte < BYTE_81 || i_data_byte == BYTE_FF) n_gbk_fail = 1'b1;
            else n_gbk_trail_due = 1'b1;
        end

        priority if (r_utf8_cont_left != 2'd0) begin
            if ((i_data_byte & MASK_C0) != BYTE_80) n_utf8_fail = 1'b1;
            n_utf8_cont_left = r_utf8_cont_left - 2'd1;
        end else if ((i_data_byte & BYTE_80) == BYTE_00) begin
            n_utf8_cont_left = 2'd0;
        end else if ((i_data_byte & MASK_E0) == MASK_C0) begin
            n_utf8_cont_left = 2'd1;
        end else if ((i_data_byte & MASK_F0) == MASK_E0) begin
            n_utf8_cont_left = 2'd2;
        end else if ((i_data_byte & MASK_F8) == MASK_F0) begin
            n_utf8_cont_left = 2'd3;
        end else begin
            n_utf8_fail = 1'b1;
        end

        if (r_length_odd) n_le = surrogate_step(i_data_byte, r_le);
        else n_be = surrogate_step(i_data_byte, r_be);
    end

    always_comb begin
        o_push            = i_accept && i_last_byte;
        o_snap.head_bytes = n_head_bytes;
        o_snap.byte_count = n_byte_count;
        o_snap.ascii_ok   = !n_ascii_fail;
        o_snap.gbk_ok     = !n_gbk_fail && !n_gbk_trail_due;
        o_snap.utf8_ok    = !n_utf8_fail && (n_utf8_cont_left == 2'd0);
        o_snap.le_ok      = !n_length_odd && !n_le.fail && !n_le.low_due;
        o_snap.be_ok      = !n_length_odd && !n_be.fail && !n_be.low_due;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_head_bytes     <= '0;
            r_byte_count     <= '0;
            r_length_odd     <= 1'b0;
            r_ascii_fail     <= 1'b0;
            r_gbk_trail_due  <= 1'b0;
            r_gbk_fail       <= 1'b0;
            r_utf8_cont_left <= '0;
            r_utf8_fail      <= 1'b0;
            r_le             <= '0;
            r_be             <= '0;
        end else if (i_accept) begin
            r_head_bytes     <= n_head_bytes;
            r_byte_count     <= n_byte_count;
            r_length_odd     <= n_length_odd;
            r_ascii_fail     <= n_ascii_fail;
            r_gbk_trail_due  <= n_gbk_trail_due;
            r_gbk_fail       <= n_gbk_fail;
            r_utf8_cont_left <= n_utf8_cont_left;
            r_utf8_fail      <= n_utf8_fail;
            r_le             <= n_le;
            r_be             <= n_be;
        end
    end

    `CSD_ASSERT_IMP(a_count_sat, i_clk, i_rst_n, 1'b1, r_byte_count <= BYTE_COUNT_MAX, "byte count past saturation")
    `CSD_ASSERT_NXT(a_clear_on_last, i_clk, i_rst_n, i_accept && i_last_byte, r_byte_count == 3'd0 && !r_length_odd, "stream state not cleared after last word")

endmodule

// ===== sv/csd_queue.sv =====
`include "charset_detect_stream_core_defines.svh"

module csd_queue
    import csd_pkg::*;
#(
    parameter int unsigned DEPTH = CSD_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_snap i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_snap o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_snap            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `CSD_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `CSD_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")

endmodule

// ===== sv/csd_back.sv =====
`include "charset_detect_stream_core_defines.svh"

module csd_back
    import csd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_expected,
    input  logic       i_q_valid,
    input  t_snap      i_q_data,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_charset,
    output logic [1:0] o_bom_size,
    output logic       o_accepted
);

    logic       r_valid;
    logic [2:0] r_charset;
    logic [1:0] r_bom_size;
    logic       r_accepted;

    t_charset   bom_cs;
    t_charset   cont_cs;
    logic [2:0] n_charset;
    logic [1:0] n_bom_size;
    logic       n_accepted;

    assign o_q_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        bom_cs     = bom_charset(i_q_data.head_bytes, i_q_data.byte_count);
        cont_cs    = content_charset(i_q_data);
        n_charset  = 3'(bom_cs);
        n_bom_size = bom_size(bom_cs);
        n_accepted = 1'b1;
        if (i_expected != 3'(CS_UNKNOWN) && i_expected != n_charset) begin
            if (n_bom_size != BOM_SIZE_NONE || 3'(cont_cs) != i_expected) begin
                n_accepted = 1'b0;
            end else begin
                n_charset = i_expected;
            end
        end
        if (n_accepted && n_charset == 3'(CS_UNKNOWN)) begin
            n_charset  = 3'(cont_cs);
            n_bom_size = BOM_SIZE_NONE;
        end
        if (n_charset == 3'(CS_UNKNOWN)) begin
            n_accepted = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_charset  <= n_charset;
            r_bom_size <= n_bom_size;
            r_accepted <= n_accepted;
        end
    end

    assign o_valid    = r_valid;
    assign o_charset  = r_charset;
    assign o_bom_size = r_bom_size;
    assign o_accepted = r_accepted;

    `CSD_ASSERT_IMP(a_accept_known, i_clk, i_rst_n, r_valid && r_accepted, r_charset != 3'(CS_UNKNOWN), "accepted word with unknown charset")
    `CSD_ASSERT_IMP(a_bom_charset, i_clk, i_rst_n, r_valid && r_bom_size != BOM_SIZE_NONE, r_charset == 3'(CS_UTF8) || r_charset == 3'(CS_LE) || r_charset == 3'(CS_BE), "bom size without bom charset")

endmodule

// ===== sv/charset_detect_stream_core.sv =====
// Streaming text charset detector. Takes one byte per cycle with a last-byte
// mark and, for each buffer, returns one word: detected charset, byte order
// mark size to skip and an accept flag checked against expected_charset
// (register 0, byte address 0; 0 means auto). Bytes go in back to back at one
// per cycle unless stalled, updating the front-end validator state per byte.
// A buffer's summary is written into the queue and its result then registered
// in the output register. A two-entry queue and the output register absorb
// output stalls, so input stalls only when both hold results not yet taken.
// Write the register only while no buffer is in flight.
module charset_detect_stream_core
    import csd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = CSD_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_charset,
    output logic [1:0]  o_bom_size,
    output logic        o_accepted,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0] r_expected;
    logic       accept;
    logic       push;
    t_snap      push_snap;
    logic       q_full;
    logic       q_valid;
    t_snap      q_data;
    logic       q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, r_expected} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= 3'd0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_expected <= pwdata[2:0];
        end
    end

    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    csd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_snap      (push_snap)
    );

    csd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_snap),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    csd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_expected (r_expected),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_charset  (o_charset),
        .o_bom_size (o_bom_size),
        .o_accepted (o_accepted)
    );

endmodule
